FILE: rtl/pfre_pkg.sv
// ---------------------------------------------------------------------------
// pfre_pkg
// Shared constants and codes of the page frame replacement engine.
// ---------------------------------------------------------------------------
package pfre_pkg;

  // default sizing
  localparam int FRAMES_DEFAULT   = 128;
  localparam int AGE_BITS_DEFAULT = 32;

  // configuration reset values
  localparam logic [2:0]  POLICY_RESET = 3'd0;
  localparam logic [7:0]  FRAMES_RESET = 8'd128;
  localparam logic [15:0] TAU_RESET    = 16'd49;

  // replacement policies
  localparam logic [2:0] POL_FIFO   = 3'd0;
  localparam logic [2:0] POL_RANDOM = 3'd1;
  localparam logic [2:0] POL_CLOCK  = 3'd2;
  localparam logic [2:0] POL_ESC    = 3'd3;
  localparam logic [2:0] POL_AGING  = 3'd4;
  localparam logic [2:0] POL_WS     = 3'd5;

  // item kinds
  localparam logic [1:0] MODE_REF    = 2'd0;
  localparam logic [1:0] MODE_MAP    = 2'd1;
  localparam logic [1:0] MODE_VICTIM = 2'd2;

  // register indexes
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_FRAMES = 2'd1;
  localparam logic [1:0] REG_TAU    = 2'd2;

  // random policy: bits of the supplied value
  localparam int RND_BITS = 31;

endpackage

FILE: rtl/pfre_ram.sv
// ---------------------------------------------------------------------------
// pfre_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pfre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/page_frame_replacement_engine_core.sv
// ---------------------------------------------------------------------------
// page_frame_replacement_engine_core
// Per-frame referenced/modified bits and age words with a victim selector.
// ---------------------------------------------------------------------------
// Items arrive on the s_axis channel, one transfer per item; tuser is the
// item kind (reference, map, victim request). Reference and map items give
// no result. A victim request gives one transfer on m_axis carrying the
// chosen frame. Fifo takes the hand; random works out the remainder one bit
// per cycle in a subtract and compare unit; clock passes over the frames,
// clearing referenced ones; enhanced second chance seeks the first frame of
// each class; aging and working set read each frame's age from the age RAM
// and write it back, under working set only when referenced. The cfg channel
// is always ready; the user is to write it only while the block is idle,
// which the block does not enforce. After reset the age RAM is cleared, one
// frame a cycle; s_axis_tready stays low meanwhile. The result sits in an
// output register: reference and map items keep being taken while it waits,
// and a further victim request finishes its scan and then holds until m_axis_tready.
// ---------------------------------------------------------------------------
module page_frame_replacement_engine_core
  import pfre_pkg::*;
#(
  parameter int FRAMES   = FRAMES_DEFAULT,
  parameter int AGE_BITS = AGE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // frame[6:0], is_write[7], now_time[39:8],
                                     // random_value[70:40], zero[71]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // victim_frame[6:0], zero[7]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_CLK, S_ESC, S_RD, S_EV, S_DONE
  } state_t;

  state_t              state;
  logic [2:0]          policy;
  logic [7:0]          frames_in_use;
  logic [15:0]         tau;
  logic [FRAMES-1:0]   ref_bits;
  logic [FRAMES-1:0]   mod_bits;
  logic [IW-1:0]       hand;
  logic [IW-1:0]       p;
  logic [IW-1:0]       best;
  logic [IW-1:0]       victim;
  logic [AGE_BITS-1:0] best_age;
  logic [31:0]         now_r;
  logic [31:0]         last_reset_time;
  logic [30:0]         rnd_r;
  logic [CW:0]         cnt;
  logic [CW-1:0]       rem;
  logic [4:0]          bit_idx;
  logic                esc_clear;
  logic                esc_only;
  logic [3:0]          cls_found;
  logic [IW-1:0]       cls_first [4];
  logic                ovalid;
  logic [6:0]          odata;
  logic                out_load;

  // input fields
  logic [1:0]  in_mode;
  logic [6:0]  in_frame;
  logic        in_write;
  logic [31:0] in_now;
  logic [30:0] in_rnd;
  logic        in_acc;
  logic        in_ok;
  logic [IW-1:0] fi;

  assign in_mode  = s_axis_tuser;
  assign in_frame = s_axis_tdata[6:0];
  assign in_write = s_axis_tdata[7];
  assign in_now   = s_axis_tdata[39:8];
  assign in_rnd   = s_axis_tdata[70:40];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_ok    = (32'(in_frame) < 32'(FRAMES));
  assign fi       = IW'(in_frame);

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {1'b0, odata};
  assign out_load      = (state == S_DONE) && (!ovalid || m_axis_tready);

  // managed frame count, clamped to 1..FRAMES
  logic [CW-1:0] n;
  always_comb begin
    if (frames_in_use == 8'd0) begin
      n = CW'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n = CW'(FRAMES);
    end else begin
      n = CW'(frames_in_use);
    end
  end

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] q, input logic [CW-1:0] cnt_n);
    logic [CW:0] s;
    s = (CW+1)'(q) + 1'b1;
    return (s >= (CW+1)'(cnt_n)) ? '0 : IW'(s);
  endfunction

  logic [IW-1:0] h0;
  logic          last_frame;
  assign h0         = ((CW+1)'(hand) >= (CW+1)'(n)) ? '0 : hand;
  assign last_frame = (cnt == (CW+1)'(n) - 1'b1);

  // remainder step for the random policy
  logic [CW:0] rem2;
  logic [CW:0] rem_sub;
  logic        rem_ge;
  assign rem2    = {rem, rnd_r[bit_idx]};
  assign rem_ge  = (rem2 >= (CW+1)'(n));
  assign rem_sub = rem_ge ? rem2 - (CW+1)'(n) : rem2;

  // enhanced second chance: class of the frame being scanned and pick
  logic [1:0]    cls;
  logic          esc_rec;
  logic [3:0]    found_now;
  logic [IW-1:0] first_now [4];
  logic [IW-1:0] esc_pick;
  assign cls     = {ref_bits[p], mod_bits[p]};
  assign esc_rec = !esc_only && !cls_found[cls];
  always_comb begin
    found_now = cls_found;
    for (int k = 0; k < 4; k++) begin
      first_now[k] = cls_first[k];
    end
    if (esc_rec) begin
      found_now[cls] = 1'b1;
      first_now[cls] = p;
    end
    priority if (found_now[0]) esc_pick = first_now[0];
    else if (found_now[1]) esc_pick = first_now[1];
    else if (found_now[2]) esc_pick = first_now[2];
    else if (found_now[3]) esc_pick = first_now[3];
    else esc_pick = hand;
  end

  // age RAM and the per-frame age update
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [AGE_BITS-1:0] ram_wdata;
  logic [AGE_BITS-1:0] ram_rdata;
  logic [AGE_BITS-1:0] t_age;
  logic [AGE_BITS-1:0] ws_diff;
  logic [AGE_BITS-1:0] age_new;
  logic                ws_old;
  logic                best_upd;
  logic [IW-1:0]       best_now;

  // age difference wraps at the age width
  assign t_age   = AGE_BITS'(now_r);
  assign ws_diff = t_age - ram_rdata;
  assign ws_old  = !ref_bits[p] && (64'(ws_diff) > 64'(tau));
  always_comb begin
    if (policy == POL_AGING) begin
      age_new = {ref_bits[p], ram_rdata[AGE_BITS-1:1]};
    end else begin
      age_new = ref_bits[p] ? t_age : ram_rdata;
    end
  end
  assign best_upd = (cnt == '0) || (age_new < best_age);
  assign best_now = best_upd ? p : best;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_waddr = fi;
        ram_wdata = (policy == POL_WS) ? AGE_BITS'(in_now) : '0;
        ram_we    = in_acc && (in_mode == MODE_MAP) && in_ok &&
                    (policy == POL_AGING || policy == POL_WS);
      end
      S_EV: begin
        ram_wdata = age_new;
        ram_we    = (policy == POL_AGING) || ref_bits[p];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pfre_ram #(
    .WIDTH(AGE_BITS),
    .DEPTH(FRAMES)
  ) u_age_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(p),
    .rdata(ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= POLICY_RESET;
      frames_in_use <= FRAMES_RESET;
      tau           <= TAU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLICY: policy        <= cfg_data[2:0];
        REG_FRAMES: frames_in_use <= cfg_data[7:0];
        REG_TAU:    tau           <= cfg_data;
        default:    ;
      endcase
    end
  end

  // sequencer, frame state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      p               <= '0;
      hand            <= '0;
      ref_bits        <= '0;
      mod_bits        <= '0;
      last_reset_time <= '0;
      ovalid          <= 1'b0;
      cnt             <= '0;
    end else begin
      if (out_load) begin
        ovalid <= 1'b1;
        odata  <= 7'(victim);
      end else if (m_axis_tvalid && m_axis_tready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        // zero the age RAM after reset
        S_CLEAR: begin
          p <= p + 1'b1;
          if (32'(p) == FRAMES - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            now_r <= in_now;
            rnd_r <= in_rnd;
            unique case (in_mode)
              MODE_REF: begin
                if (in_ok) begin
                  ref_bits[fi] <= 1'b1;
                  if (in_write) mod_bits[fi] <= 1'b1;
                end
              end
              MODE_MAP: begin
                if (in_ok) begin
                  ref_bits[fi] <= 1'b0;
                  mod_bits[fi] <= 1'b0;
                end
              end
              MODE_VICTIM: begin
                p         <= h0;
                cnt       <= '0;
                rem       <= '0;
                bit_idx   <= 5'(RND_BITS - 1);
                cls_found <= '0;
                esc_only  <= 1'b0;
                esc_clear <= (in_now - last_reset_time) > 32'(tau);
                unique case (policy)
                  POL_RANDOM: begin
                    hand  <= h0;
                    state <= S_DIV;
                  end
                  POL_CLOCK: begin
                    hand  <= h0;
                    state <= S_CLK;
                  end
                  POL_ESC: begin
                    hand <= h0;
                    if ((in_now - last_reset_time) > 32'(tau)) begin
                      last_reset_time <= in_now;
                    end
                    state <= S_ESC;
                  end
                  POL_AGING, POL_WS: begin
                    hand  <= h0;
                    state <= S_RD;
                  end
                  default: begin
                    victim <= h0;
                    hand   <= adv(h0, n);
                    state  <= S_DONE;
                  end
                endcase
              end
              default: ;
            endcase
          end
        end
        // random: one remainder bit per cycle
        S_DIV: begin
          rem     <= CW'(rem_sub);
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == '0) begin
            victim <= IW'(rem_sub);
            state  <= S_DONE;
          end
        end
        // clock: pass over and clear referenced frames
        S_CLK: begin
          hand <= adv(p, n);
          p    <= adv(p, n);
          cnt  <= cnt + 1'b1;
          if (!ref_bits[p]) begin
            victim <= p;
            state  <= S_DONE;
          end else begin
            ref_bits[p] <= 1'b0;
            if (cnt == (CW+1)'({n, 1'b0}) - 1'b1) begin
              victim <= p;
              state  <= S_DONE;
            end
          end
        end
        // enhanced second chance: first frame of each class
        S_ESC: begin
          if (esc_rec) begin
            cls_found[cls] <= 1'b1;
            cls_first[cls] <= p;
          end
          if (esc_clear) begin
            ref_bits[p] <= 1'b0;
            if (cls == 2'd0) esc_only <= 1'b1;
          end
          p   <= adv(p, n);
          cnt <= cnt + 1'b1;
          if ((!esc_only && cls == 2'd0 && !esc_clear) || last_frame) begin
            victim <= esc_pick;
            hand   <= adv(esc_pick, n);
            state  <= S_DONE;
          end
        end
        // aging and working set: age read in flight
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          ref_bits[p] <= 1'b0;
          best        <= best_now;
          best_age    <= best_upd ? age_new : best_age;
          p           <= adv(p, n);
          cnt         <= cnt + 1'b1;
          if (policy == POL_WS && ws_old) begin
            victim <= p;
            hand   <= adv(p, n);
            state  <= S_DONE;
          end else if (last_frame) begin
            victim <= best_now;
            hand   <= adv(best_now, n);
            state  <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        // hand the victim to the output register
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // hand stays inside the frame array
  assert property (@(posedge clk) disable iff (rst) 32'(hand) < FRAMES)
    else $error("hand beyond frame array");

  // a victim request holds off further input
  assert property (@(posedge clk) disable iff (rst)
    in_acc && in_mode == MODE_VICTIM |=> !s_axis_tready)
    else $error("input taken during victim scan");

  // enhanced second chance, aging and working set scans never run past the managed frames
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ESC || state == S_RD || state == S_EV) |-> cnt < (CW+1)'(n))
    else $error("scan counter overrun");

  // no input during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_axis_tready)
    else $error("input taken while clearing");

  // a result is loaded only from the done state
  assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(state) == S_DONE)
    else $error("result without finished scan");

endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the page frame replacement engine core: a directed
// table then random reference, map and victim traffic under every policy,
// with bursty input, a stalling result side and results checked against a
// predictor of the frame state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pfre_pkg::*;

  localparam int NF = 128;
  localparam int EXP_DEPTH = 256;

  // codes outside the defined set
  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam logic [2:0] POL_UNDEF  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = MODE_REF;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_POLICY;
  logic [15:0] cfg_data = '0;

  page_frame_replacement_engine_core u_dut (.*);

  always #10 clk = ~clk;

  // time limit
  initial begin
    #400ms;
    $display("simulation failed");
    $finish;
  end

  // predictor state
  logic        pr_ref  [NF];
  logic        pr_mod  [NF];
  logic [31:0] pr_age  [NF];
  int unsigned pr_hand;
  logic [31:0] pr_last_clr;
  logic [2:0]  pr_policy;
  logic [7:0]  pr_frames;
  logic [15:0] pr_tau;

  // expected victims in order of request
  logic [6:0] exp_fifo [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  logic [6:0] last_pred = '0;
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  int n_victims [8];
  bit hold_off = 1'b0;
  bit long_hold = 1'b0;

  function automatic int unsigned nxt(int unsigned p, int unsigned n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  // enhanced second chance scan
  function automatic int unsigned pick_nru(int unsigned n, logic [31:0] now);
    int first [4];
    bit clr;
    bit clr_only;
    int unsigned p;
    int unsigned c;
    first = '{-1, -1, -1, -1};
    clr = (now - pr_last_clr) > {16'd0, pr_tau};
    clr_only = 1'b0;
    p = pr_hand;
    if (clr) pr_last_clr = now;
    for (int i = 0; i < n; i++) begin
      if (clr_only) begin
        pr_ref[p] = 1'b0;
      end else begin
        c = {pr_ref[p], pr_mod[p]};
        if (first[c] < 0) first[c] = p;
        if (c == 0) begin
          if (clr) clr_only = 1'b1;
          else break;
        end
        if (clr) pr_ref[p] = 1'b0;
      end
      p = nxt(p, n);
    end
    for (int k = 0; k < 4; k++)
      if (first[k] >= 0) return first[k];
    return pr_hand;
  endfunction

  // shift ages and take the first minimum
  function automatic int unsigned pick_oldest_aging(int unsigned n);
    int unsigned p, best;
    logic [31:0] best_age;
    p = pr_hand; best = pr_hand; best_age = '0;
    for (int i = 0; i < n; i++) begin
      pr_age[p] = {pr_ref[p], pr_age[p][31:1]};
      pr_ref[p] = 1'b0;
      if (i == 0 || pr_age[p] < best_age) begin
        best = p; best_age = pr_age[p];
      end
      p = nxt(p, n);
    end
    return best;
  endfunction

  function automatic int unsigned pick_outside_ws(int unsigned n, logic [31:0] now);
    int unsigned p, best;
    logic [31:0] best_age;
    p = pr_hand; best = pr_hand; best_age = '0;
    for (int i = 0; i < n; i++) begin
      if (pr_ref[p]) begin
        pr_ref[p] = 1'b0;
        pr_age[p] = now;
      end else if ((now - pr_age[p]) > {16'd0, pr_tau}) begin
        return p;
      end
      if (i == 0 || pr_age[p] < best_age) begin
        best = p; best_age = pr_age[p];
      end
      p = nxt(p, n);
    end
    return best;
  endfunction

  // update frame state for one item; returns 1 with the victim on a request
  function automatic bit predict_victim(logic [1:0] mode, logic [6:0] f, logic wr,
                                        logic [31:0] now, logic [30:0] rnd,
                                        output logic [6:0] victim);
    int unsigned n, v;
    victim = '0;
    if (mode == MODE_REF) begin
      pr_ref[f] = 1'b1;
      if (wr) pr_mod[f] = 1'b1;
      return 1'b0;
    end
    if (mode == MODE_MAP) begin
      pr_ref[f] = 1'b0;
      pr_mod[f] = 1'b0;
      if (pr_policy == POL_AGING) pr_age[f] = '0;
      else if (pr_policy == POL_WS) pr_age[f] = now;
      return 1'b0;
    end
    if (mode != MODE_VICTIM) return 1'b0;
    n = (pr_frames == 0) ? 1 : ((pr_frames > NF) ? NF : pr_frames);
    if (pr_hand >= n) pr_hand = 0;
    case (pr_policy)
      POL_RANDOM: v = rnd % n;
      POL_CLOCK: begin
        v = pr_hand;
        for (int i = 0; i < 2 * n; i++) begin
          v = pr_hand;
          pr_hand = nxt(pr_hand, n);
          if (!pr_ref[v]) break;
          pr_ref[v] = 1'b0;
        end
      end
      POL_ESC: begin
        v = pick_nru(n, now);
        pr_hand = nxt(v, n);
      end
      POL_AGING: begin
        v = pick_oldest_aging(n);
        pr_hand = nxt(v, n);
      end
      POL_WS: begin
        v = pick_outside_ws(n, now);
        pr_hand = nxt(v, n);
      end
      default: begin
        v = pr_hand;
        pr_hand = nxt(pr_hand, n);
      end
    endcase
    victim = v[6:0];
    return 1'b1;
  endfunction

  // result side: stall pattern plus a long hold-off on request
  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else if (long_hold) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 9) > 2);
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (exp_wr == exp_rd) begin
        errors++;
        if (errors <= 10) $display("unexpected result frame %0d", m_axis_tdata[6:0]);
      end else begin
        if (m_axis_tdata[6:0] !== exp_fifo[exp_rd % EXP_DEPTH] || m_axis_tdata[7] !== 1'b0)
        begin
          errors++;
          if (errors <= 10)
            $display("victim mismatch: expected %0d got %0d",
                     exp_fifo[exp_rd % EXP_DEPTH], m_axis_tdata);
        end
        exp_rd++;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_POLICY: pr_policy = val[2:0];
      REG_FRAMES: pr_frames = val[7:0];
      default:    pr_tau = val;
    endcase
  endtask

  task automatic drain;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // send one item, with valid held high across back-to-back transfers
  int burst_left = 0;
  task automatic send_item(logic [1:0] mode, logic [6:0] f, logic wr, logic [31:0] now,
                           logic [30:0] rnd);
    logic [6:0] v;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      @(negedge clk);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {1'b0, rnd, now, wr, f};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    n_items++;
    if (predict_victim(mode, f, wr, now, rnd, v)) begin
      exp_fifo[exp_wr % EXP_DEPTH] = v;
      exp_wr++;
      last_pred = v;
      n_victims[pr_policy]++;
    end
  endtask

  task automatic idle_input;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  typedef struct {
    logic [1:0]  mode;
    logic [6:0]  frame;
    logic        wr;
    logic [31:0] now;
    logic [30:0] rnd;
  } item_t;

  // directed table under the fifo policy at reset values
  item_t dir_tab [7] = '{
    '{MODE_VICTIM, 7'd0,   1'b0, 32'd1,          31'd0},
    '{MODE_VICTIM, 7'd0,   1'b0, 32'd2,          31'd0},
    '{MODE_REF,    7'd127, 1'b1, 32'hFFFF_FFFF,  31'h7FFF_FFFF},
    '{MODE_MAP,    7'd0,   1'b0, 32'd0,          31'd0},
    '{MODE_UNDEF,  7'd5,   1'b1, 32'd7,          31'd9},
    '{MODE_VICTIM, 7'd127, 1'b1, 32'hFFFF_FFFF,  31'h7FFF_FFFF},
    '{MODE_REF,    7'd64,  1'b0, 32'h8000_0000,  31'h4000_0000}
  };

  // fifo victims right after reset, one per victim row
  logic [6:0] dir_expect [3] = '{7'd0, 7'd1, 7'd2};

  initial begin
    logic [31:0] clock_now;
    int unsigned pol;
    int unsigned dk;
    for (int i = 0; i < NF; i++) begin
      pr_ref[i] = 1'b0; pr_mod[i] = 1'b0; pr_age[i] = '0;
    end
    pr_hand = 0; pr_last_clr = '0;
    pr_policy = POL_FIFO; pr_frames = 8'd128; pr_tau = 16'd49;
    foreach (n_victims[i]) n_victims[i] = 0;
    dk = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, fifo at reset values: first victims read straight off
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].mode, dir_tab[i].frame, dir_tab[i].wr,
                dir_tab[i].now, dir_tab[i].rnd);
      if (dir_tab[i].mode == MODE_VICTIM) begin
        if (dk < 3 && last_pred !== dir_expect[dk]) begin
          errors++;
          if (errors <= 10)
            $display("directed victim: expected %0d got %0d", dir_expect[dk], last_pred);
        end
        dk++;
      end
    end
    idle_input();
    drain();
    // random policy extremes, frame count extremes
    write_reg(REG_POLICY, {13'd0, POL_RANDOM});
    write_reg(REG_FRAMES, 16'd0);
    send_item(MODE_VICTIM, 7'd0, 1'b0, 32'd0, 31'h7FFF_FFFF);
    idle_input();
    drain();
    write_reg(REG_FRAMES, 16'd255);
    send_item(MODE_VICTIM, 7'd0, 1'b0, 32'd0, 31'h7FFF_FFFF);
    send_item(MODE_VICTIM, 7'd0, 1'b0, 32'd0, 31'd127);
    idle_input();
    drain();
    write_reg(REG_POLICY, {13'd0, POL_UNDEF});
    send_item(MODE_VICTIM, 7'd0, 1'b0, 32'd0, 31'd0);
    idle_input();
    drain();

    // random phases through all policies and settings
    clock_now = 32'hFFFF_FF00;
    for (int ph = 0; ph < 14; ph++) begin
      pol = (ph < 8) ? ph : $urandom_range(0, 5);
      write_reg(REG_POLICY, pol[15:0]);
      case (ph % 4)
        0: write_reg(REG_FRAMES, 16'd128);
        1: write_reg(REG_FRAMES, 16'd1);
        2: write_reg(REG_FRAMES, 16'($urandom_range(2, 20)));
        default: write_reg(REG_FRAMES, 16'($urandom_range(0, 255)));
      endcase
      case (ph % 3)
        0: write_reg(REG_TAU, 16'($urandom_range(0, 60)));
        1: write_reg(REG_TAU, (ph == 4) ? 16'hFFFF : 16'd0);
        default: write_reg(REG_TAU, 16'($urandom));
      endcase
      if (ph == 5) begin
        // long stall on the result side while items keep coming
        hold_off = 1'b1;
        fork
          begin repeat (3000) @(posedge clk); hold_off = 1'b0; end
        join_none
      end
      long_hold = (ph % 2);
      for (int k = 0; k < 130; k++) begin
        logic [1:0] md;
        int r;
        r = $urandom_range(0, 99);
        md = (r < 55) ? MODE_REF : (r < 75) ? MODE_MAP : (r < 98) ? MODE_VICTIM : MODE_UNDEF;
        clock_now += $urandom_range(0, 40);
        if ($urandom_range(0, 49) == 0) clock_now = $urandom;
        send_item(md, 7'($urandom_range(0, (pr_frames > 0 && pr_frames < 128) ?
                                          pr_frames + 3 : 127)),
                  1'($urandom), clock_now, 31'($urandom));
      end
      idle_input();
      drain();
    end

    $display("items %0d, results %0d, victims per policy f%0d r%0d c%0d e%0d a%0d w%0d",
             n_items, n_results, n_victims[0] + n_victims[6] + n_victims[7],
             n_victims[1], n_victims[2], n_victims[3], n_victims[4], n_victims[5]);
    $display("frame counts 0..255, tau 0..65535 and a long result stall covered");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("mismatches: %0d", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
